/* rtl/core/assert_macros.svh */
// Assertion macros shared by the entry decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCED_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define PCED_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define PCED_ASSERT(lbl, clk, rst_n, prop)
`define PCED_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/core/pced_pkg.sv */
// Shared types and constants of the entry decoder.
`default_nettype none
package pced_pkg;

	localparam int unsigned MAX_KEY_DEF = 32;
	localparam int unsigned LEN_W       = 6;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       byte_out;
		logic [4:0]       key_position;
		logic [LEN_W-1:0] shared_len;
		logic [LEN_W-1:0] unshared_len;
		logic [31:0]      value_len;
		logic [1:0]       error_code;
		logic             entry_end;
	} result_t;

	typedef struct packed {
		logic accept;
		logic rep_rd;
		logic rep_emit;
		logic trunc_emit;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic need_replay;
		logic trunc_after;
		logic rep_last;
	} status_t;

endpackage
`default_nettype wire

/* rtl/core/pced_in_if.sv */
// Input byte channel of the entry decoder.
`default_nettype none
interface pced_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/pced_out_if.sv */
// Result channel of the entry decoder.
`default_nettype none
interface pced_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_out;
	logic [4:0]  key_position;
	logic [5:0]  shared_len;
	logic [5:0]  unshared_len;
	logic [31:0] value_len;
	logic [1:0]  error_code;
	logic        entry_end;

	modport source (output valid, output kind, output byte_out, output key_position,
		output shared_len, output unshared_len, output value_len, output error_code,
		output entry_end, input ready);
	modport sink (input valid, input kind, input byte_out, input key_position,
		input shared_len, input unshared_len, input value_len, input error_code,
		input entry_end, output ready);
endinterface
`default_nettype wire

/* rtl/core/pced_datapath.sv */
// Datapath: varint header decode, key memory, replay index and result register.
`default_nettype none
`include "assert_macros.svh"
module pced_datapath #(
	parameter int unsigned MaxKey = pced_pkg::MAX_KEY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                out_ready,
	input  pced_pkg::cmd_t      cmd,
	output pced_pkg::status_t   status,
	output pced_pkg::result_t   res,
	output logic                res_valid
);
	import pced_pkg::*;

	localparam int unsigned AW = (MaxKey > 1) ? $clog2(MaxKey) : 1;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_KEY    = 2'd1;
	localparam logic [1:0] PH_VALUE  = 2'd2;

	localparam logic [1:0] FLD_SHARED   = 2'd0;
	localparam logic [1:0] FLD_UNSHARED = 2'd1;
	localparam logic [1:0] FLD_VALUE    = 2'd2;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_KEY    = 2'd1;
	localparam logic [1:0] KIND_VALUE  = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_TRUNC   = 2'd0;
	localparam logic [1:0] ERR_OVERRUN = 2'd1;
	localparam logic [1:0] ERR_SHARED  = 2'd2;
	localparam logic [1:0] ERR_KEYLEN  = 2'd3;

	localparam logic [2:0] VARINT_LAST = 3'd4;

	// decode state
	logic [LEN_W-1:0] prev_len_q, prev_len_n;
	logic [1:0]       fidx_q, fidx_n;
	logic [31:0]      acc_q, acc_n;
	logic [2:0]       vcnt_q, vcnt_n;
	logic [LEN_W-1:0] held_sh_q, held_sh_n;
	logic [LEN_W-1:0] held_un_q, held_un_n;
	logic [LEN_W-1:0] key_left_q, key_left_n;
	logic [31:0]      val_left_q, val_left_n;
	logic [1:0]       phase_q, phase_n;
	logic             err_lat_q, err_lat_n;

	// replay and result slot
	logic [LEN_W-1:0] rep_idx_q;
	logic [LEN_W-1:0] rep_len_q;
	logic             rep_empty_q;
	logic [7:0]       rd_q;
	logic [7:0]       key_mem [MaxKey];
	result_t          res_q;
	logic             valid_q;

	logic [31:0] contrib;
	logic [31:0] acc_v;
	logic [32:0] key_sum;
	result_t     prim;
	result_t     rep_res;
	result_t     trunc_res;
	logic        prim_valid;
	logic        err_hit;
	logic [1:0]  err_code;
	logic        mem_we;
	logic        replay;
	logic        trunc_after;
	logic        ld_prim;
	logic        ld_any;
	logic        slot_free;
	logic        rep_last;

	// place the 7 payload bits (only the low 4 in the fifth byte) at the slot of the current varint byte
	always_comb begin
		case (vcnt_q)
			3'd0: contrib = {25'd0, data_byte[6:0]};
			3'd1: contrib = {18'd0, data_byte[6:0], 7'd0};
			3'd2: contrib = {11'd0, data_byte[6:0], 14'd0};
			3'd3: contrib = {4'd0, data_byte[6:0], 21'd0};
			default: contrib = {data_byte[3:0], 28'd0};
		endcase
	end

	assign acc_v   = acc_q | contrib;
	assign key_sum = {27'd0, held_sh_q} + {1'b0, acc_v};

	always_comb begin
		prev_len_n = prev_len_q;
		fidx_n     = fidx_q;
		acc_n      = acc_q;
		vcnt_n     = vcnt_q;
		held_sh_n  = held_sh_q;
		held_un_n  = held_un_q;
		key_left_n = key_left_q;
		val_left_n = val_left_q;
		phase_n    = phase_q;
		err_lat_n  = err_lat_q;
		prim       = '0;
		prim_valid = 1'b0;
		err_hit    = 1'b0;
		err_code   = ERR_TRUNC;
		mem_we     = 1'b0;
		replay     = 1'b0;
		trunc_after = 1'b0;

		if (!err_lat_q) begin
			case (phase_q)
				PH_HEADER: begin
					if (data_byte[7]) begin
						if (vcnt_q == VARINT_LAST) begin
							err_hit  = 1'b1;
							err_code = ERR_OVERRUN;
						end else begin
							vcnt_n = vcnt_q + 3'd1;
							acc_n  = acc_v;
						end
					end else begin
						acc_n  = '0;
						vcnt_n = '0;
						case (fidx_q)
							FLD_SHARED: begin
								if (acc_v > {26'd0, prev_len_q}) begin
									err_hit  = 1'b1;
									err_code = ERR_SHARED;
								end else begin
									held_sh_n = acc_v[LEN_W-1:0];
									fidx_n    = FLD_UNSHARED;
								end
							end
							FLD_UNSHARED: begin
								if (key_sum > 33'(MaxKey)) begin
									err_hit  = 1'b1;
									err_code = ERR_KEYLEN;
								end else begin
									held_un_n = acc_v[LEN_W-1:0];
									fidx_n    = FLD_VALUE;
								end
							end
							default: begin
								fidx_n     = FLD_SHARED;
								prim_valid = 1'b1;
								prim.kind  = KIND_HEADER;
								prim.shared_len   = held_sh_q;
								prim.unshared_len = held_un_q;
								prim.value_len    = acc_v;
								prim.entry_end = (held_un_q == '0) && (acc_v == '0) &&
									(held_sh_q == '0);
								replay     = (held_sh_q != '0);
								prev_len_n = held_sh_q;
								key_left_n = held_un_q;
								val_left_n = acc_v;
								if (held_un_q != '0)
									phase_n = PH_KEY;
								else if (acc_v != '0)
									phase_n = PH_VALUE;
								else
									phase_n = PH_HEADER;
							end
						endcase
					end
				end
				PH_KEY: begin
					mem_we     = 1'b1;
					prev_len_n = prev_len_q + 1'b1;
					key_left_n = key_left_q - 1'b1;
					prim_valid = 1'b1;
					prim.kind  = KIND_KEY;
					prim.byte_out     = data_byte;
					prim.key_position = prev_len_q[4:0];
					prim.entry_end    = (key_left_n == '0) && (val_left_q == '0);
					if (key_left_n == '0)
						phase_n = (val_left_q != '0) ? PH_VALUE : PH_HEADER;
				end
				default: begin
					val_left_n     = val_left_q - 32'd1;
					prim_valid     = 1'b1;
					prim.kind      = KIND_VALUE;
					prim.byte_out  = data_byte;
					prim.entry_end = (val_left_n == '0);
					if (val_left_n == '0)
						phase_n = PH_HEADER;
				end
			endcase

			if (err_hit) begin
				prim            = '0;
				prim_valid      = 1'b1;
				prim.kind       = KIND_ERROR;
				prim.error_code = err_code;
				err_lat_n       = 1'b1;
			end else if (last_byte && (phase_n != PH_HEADER || fidx_n != FLD_SHARED ||
					vcnt_n != '0)) begin
				if (prim_valid) begin
					trunc_after = 1'b1;
				end else begin
					prim_valid      = 1'b1;
					prim.kind       = KIND_ERROR;
					prim.error_code = ERR_TRUNC;
				end
			end
		end

		// region end: drop all decode state
		if (last_byte) begin
			prev_len_n = '0;
			fidx_n     = FLD_SHARED;
			acc_n      = '0;
			vcnt_n     = '0;
			held_sh_n  = '0;
			held_un_n  = '0;
			key_left_n = '0;
			val_left_n = '0;
			phase_n    = PH_HEADER;
			err_lat_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_len_q <= '0;
			fidx_q     <= FLD_SHARED;
			acc_q      <= '0;
			vcnt_q     <= '0;
			held_sh_q  <= '0;
			held_un_q  <= '0;
			key_left_q <= '0;
			val_left_q <= '0;
			phase_q    <= PH_HEADER;
			err_lat_q  <= 1'b0;
		end else if (cmd.accept) begin
			prev_len_q <= prev_len_n;
			fidx_q     <= fidx_n;
			acc_q      <= acc_n;
			vcnt_q     <= vcnt_n;
			held_sh_q  <= held_sh_n;
			held_un_q  <= held_un_n;
			key_left_q <= key_left_n;
			val_left_q <= val_left_n;
			phase_q    <= phase_n;
			err_lat_q  <= err_lat_n;
		end
	end

	// key memory: one write port for new key bytes, one registered read port for replay
	always_ff @(posedge clk) begin
		if (cmd.accept && mem_we)
			key_mem[prev_len_q[AW-1:0]] <= data_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.rep_rd)
			rd_q <= key_mem[rep_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_idx_q   <= '0;
			rep_len_q   <= '0;
			rep_empty_q <= 1'b0;
		end else if (cmd.accept) begin
			rep_idx_q   <= '0;
			rep_len_q   <= held_sh_q;
			rep_empty_q <= (held_un_q == '0) && (acc_v == '0);
		end else if (cmd.rep_emit) begin
			rep_idx_q <= rep_idx_q + 1'b1;
		end
	end

	assign rep_last = ((rep_idx_q + 1'b1) == rep_len_q);

	always_comb begin
		rep_res              = '0;
		rep_res.kind         = KIND_KEY;
		rep_res.byte_out     = rd_q;
		rep_res.key_position = rep_idx_q[4:0];
		rep_res.entry_end    = rep_empty_q && rep_last;
		trunc_res            = '0;
		trunc_res.kind       = KIND_ERROR;
		trunc_res.error_code = ERR_TRUNC;
	end

	assign slot_free = !valid_q || out_ready;
	assign ld_prim   = cmd.accept && prim_valid;
	assign ld_any    = ld_prim || cmd.rep_emit || cmd.trunc_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ld_any)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_prim)
			res_q <= prim;
		else if (cmd.rep_emit)
			res_q <= rep_res;
		else if (cmd.trunc_emit)
			res_q <= trunc_res;
	end

	assign res       = res_q;
	assign res_valid = valid_q;

	assign status.slot_free   = slot_free;
	assign status.need_replay = replay;
	assign status.trunc_after = trunc_after;
	assign status.rep_last    = rep_last;

	`PCED_ASSERT(a_single_load, clk, arst_n, ($onehot0({ld_prim, cmd.rep_emit, cmd.trunc_emit})))
	`PCED_ASSERT_NEVER(a_load_busy_slot, clk, arst_n, (ld_any && !slot_free))
	`PCED_ASSERT(a_replay_in_range, clk, arst_n, (cmd.rep_rd |-> (rep_idx_q < rep_len_q)))

endmodule
`default_nettype wire

/* rtl/core/pced_ctrl.sv */
// Controller: byte intake, prefix replay sequencing and truncation error issue.
`default_nettype none
`include "assert_macros.svh"
module pced_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pced_pkg::status_t status,
	output pced_pkg::cmd_t    cmd
);
	import pced_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_REP_RD  = 2'd1;
	localparam logic [1:0] ST_REP_OUT = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	logic [1:0] state_q, state_n;
	logic       trunc_q, trunc_n;

	assign in_ready = (state_q == ST_IDLE) && status.slot_free;

	always_comb begin
		state_n = state_q;
		trunc_n = trunc_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid && in_ready;
				if (cmd.accept) begin
					trunc_n = status.trunc_after;
					if (status.need_replay)
						state_n = ST_REP_RD;
					else if (status.trunc_after)
						state_n = ST_TRUNC;
				end
			end
			ST_REP_RD: begin
				cmd.rep_rd = 1'b1;
				state_n    = ST_REP_OUT;
			end
			ST_REP_OUT: begin
				if (status.slot_free) begin
					cmd.rep_emit = 1'b1;
					if (!status.rep_last)
						state_n = ST_REP_RD;
					else if (trunc_q)
						state_n = ST_TRUNC;
					else
						state_n = ST_IDLE;
				end
			end
			default: begin
				// truncation error closes the region
				if (status.slot_free) begin
					cmd.trunc_emit = 1'b1;
					trunc_n        = 1'b0;
					state_n        = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trunc_q <= 1'b0;
		end else begin
			state_q <= state_n;
			trunc_q <= trunc_n;
		end
	end

	`PCED_ASSERT(a_read_then_out, clk, arst_n, ((state_q == ST_REP_RD) |=> (state_q == ST_REP_OUT)))
	`PCED_ASSERT(a_trunc_pending, clk, arst_n, ((state_q == ST_TRUNC) |-> trunc_q))
	`PCED_ASSERT(a_replay_start, clk, arst_n, ((cmd.accept && status.need_replay) |=> (state_q == ST_REP_RD)))

endmodule
`default_nettype wire

/* rtl/core/prefix_compressed_entry_decoder.sv */
// A header, key or value result sits in the output register in the cycle after its transfer.
// Throughput: one byte per cycle while the result side keeps up; a header with a shared
// prefix holds the input while each shared byte takes a registered key memory read and an emit step.
// A truncation error after other results is issued from its own controller state before the next byte.
// Reset: arst_n clears decode and control state at once; the key memory is not cleared.
`default_nettype none
module prefix_compressed_entry_decoder #(
	parameter int unsigned MaxKey = pced_pkg::MAX_KEY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pced_in_if.sink     entry_bytes,
	pced_out_if.source  results
);
	import pced_pkg::*;

	cmd_t    cmd;
	status_t status;
	result_t res;
	logic    res_valid;
	logic    in_ready;

	pced_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (entry_bytes.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pced_datapath #(
		.MaxKey (MaxKey)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (entry_bytes.data_byte),
		.last_byte (entry_bytes.last_byte),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status),
		.res       (res),
		.res_valid (res_valid)
	);

	assign entry_bytes.ready    = in_ready;
	assign results.valid        = res_valid;
	assign results.kind         = res.kind;
	assign results.byte_out     = res.byte_out;
	assign results.key_position = res.key_position;
	assign results.shared_len   = res.shared_len;
	assign results.unshared_len = res.unshared_len;
	assign results.value_len    = res.value_len;
	assign results.error_code   = res.error_code;
	assign results.entry_end    = res.entry_end;

endmodule
`default_nettype wire
